FILE: rtl/offset_search_match_vote_top_assert.svh
// Assertion macros for the offset search match vote block.
// Used by offset_search_match_vote_top; expects clk and rst_n in scope.
`ifndef OFFSET_SEARCH_MATCH_VOTE_TOP_ASSERT_SVH
`define OFFSET_SEARCH_MATCH_VOTE_TOP_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define OSMV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define OSMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/osmv_pkg.sv
// Shared types and constants for the offset search match vote block.
// No dependencies; imported by offset_search_match_vote_top.
package osmv_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int CNT_W     = 19;
  localparam int MARGIN    = 32;
  localparam int SIDE_W    = 13;
  localparam int POS_W     = 16;
  localparam int MOT_W     = 15;
  localparam int SHIFT_W   = 14;
  localparam int SAMPLE_W  = 12;
  localparam int PIX_W     = 32;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 72;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SIDE_W-1:0] SIDE_SAT = SIDE_W'(MAX_SIDE);
  localparam logic signed [POS_W-1:0] POS_LO = -POS_W'(MARGIN);
  localparam logic [POS_W-1:0] MARGIN_W = POS_W'(MARGIN);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BACK_WIDTH   = 3'd0,
    REG_BACK_HEIGHT  = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_MOTION_X_MIN = 3'd4,
    REG_MOTION_X_MAX = 3'd5,
    REG_MOTION_Y_MIN = 3'd6,
    REG_MOTION_Y_MAX = 3'd7
  } cfg_reg_t;

  // Saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

FILE: rtl/offset_search_match_vote_top.sv
// Offset search match vote: classifies sample comparisons, counts matches per shift
// and reports the best shift at the end of a search. Depends on osmv_pkg and
// offset_search_match_vote_top_assert.svh.
//
// Usage: each in_ beat is one frame/background sample comparison for one candidate
// shift; in_tlast closes the shift, in_tuser closes the whole search. A search closes
// with exactly one out_ beat (offset, counts, suspect flag in out_tuser); all other
// beats produce nothing.
// Throughput: one beat per cycle while in_tready is high. The result of the closing
// beat passes through the input register, classify register, result register and
// output register before out_tvalid shows it.
// A stalled receiver holds its result in the output register while beats keep
// flowing; in_tready drops, and all stages hold, only while a second result waits
// in the result stage behind an output beat that has not been taken.
// Configuration: cfg_ready is always high; write only while no beat is in flight
// (four cycles after the last accepted beat, once any result has been taken).
// Reset: registers return to 256x256 background, origin 0, motion bounds +/-9999,
// and empty match/best state; the block accepts beats as soon as reset is released.
module offset_search_match_vote_top
  import osmv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: sample_x[11:0], sample_y[23:12], shift_x[37:24], shift_y[51:38],
  //           frame_pixel[83:52], back_pixel[115:84], zero pad[119:116]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,   // last_sample
  input  logic                  in_tuser,   // last_shift
  // out_tdata: offset_x[14:0], offset_y[29:15], best_count[48:30],
  //            sample_total[67:49], zero pad[71:68]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // suspect
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [MOT_W-1:0]      cfg_data
);

  `include "offset_search_match_vote_top_assert.svh"

  // Configuration registers
  logic [SIDE_W-1:0]        back_width_r, back_height_r;
  logic signed [SIDE_W-1:0] origin_x_r, origin_y_r;
  logic signed [MOT_W-1:0]  mx_min_r, mx_max_r, my_min_r, my_max_r;

  // Pipeline control
  logic adv, out_free;
  logic s0_valid_r, s1_valid_r, res_valid_r, out_valid_r;

  // Input register
  logic [SAMPLE_W-1:0]       s0_sx_r, s0_sy_r;
  logic signed [SHIFT_W-1:0] s0_hx_r, s0_hy_r;
  logic [PIX_W-1:0]          s0_fp_r, s0_bp_r;
  logic                      s0_last_s_r, s0_last_h_r;

  // Classify register
  logic                      s1_hit_r, s1_inb_r, s1_last_s_r, s1_last_h_r;
  logic signed [SHIFT_W-1:0] s1_hx_r, s1_hy_r;

  // Search state
  logic [CNT_W-1:0]          match_run_r, samples_run_r, best_r, samples_last_r;
  logic signed [SHIFT_W-1:0] best_h_r, best_v_r;
  logic [CNT_W-1:0]          match_run_nxt, samples_run_nxt, best_nxt, samples_last_nxt;
  logic signed [SHIFT_W-1:0] best_h_nxt, best_v_nxt;

  // Result register (closing beat of a search)
  logic [CNT_W-1:0]          res_best_r, res_samples_r;
  logic signed [SHIFT_W-1:0] res_h_r, res_v_r;

  // Output register
  logic signed [MOT_W-1:0] out_ox_r, out_oy_r;
  logic [CNT_W-1:0]        out_best_r, out_samples_r;
  logic                    out_suspect_r;

  // Stall only when a result has to move into an output register still held
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = out_free || !res_valid_r;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_width_r  <= SIDE_W'(256);
      back_height_r <= SIDE_W'(256);
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      mx_min_r      <= -MOT_W'(9999);
      mx_max_r      <= MOT_W'(9999);
      my_min_r      <= -MOT_W'(9999);
      my_max_r      <= MOT_W'(9999);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BACK_WIDTH:   back_width_r  <= cfg_data[SIDE_W-1:0];
        REG_BACK_HEIGHT:  back_height_r <= cfg_data[SIDE_W-1:0];
        REG_ORIGIN_X:     origin_x_r    <= cfg_data[SIDE_W-1:0];
        REG_ORIGIN_Y:     origin_y_r    <= cfg_data[SIDE_W-1:0];
        REG_MOTION_X_MIN: mx_min_r      <= cfg_data;
        REG_MOTION_X_MAX: mx_max_r      <= cfg_data;
        REG_MOTION_Y_MIN: my_min_r      <= cfg_data;
        REG_MOTION_Y_MAX: my_max_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the background size
  logic [SIDE_W-1:0] w_sat, h_sat;
  assign w_sat = (back_width_r  > SIDE_SAT) ? SIDE_SAT : back_width_r;
  assign h_sat = (back_height_r > SIDE_SAT) ? SIDE_SAT : back_height_r;

  // Classify: displaced position, margin test, pixel compare, motion bounds
  logic signed [POS_W-1:0] bx, by, w16, h16, w_hi, h_hi;
  logic signed [MOT_W-1:0] hx15, hy15;
  logic outside, margin_ok, pix_match, match, in_bounds;

  assign bx = $signed({{(POS_W-SAMPLE_W){1'b0}}, s0_sx_r})
            + $signed({{(POS_W-SIDE_W){origin_x_r[SIDE_W-1]}}, origin_x_r})
            + $signed({{(POS_W-SHIFT_W){s0_hx_r[SHIFT_W-1]}}, s0_hx_r});
  assign by = $signed({{(POS_W-SAMPLE_W){1'b0}}, s0_sy_r})
            + $signed({{(POS_W-SIDE_W){origin_y_r[SIDE_W-1]}}, origin_y_r})
            + $signed({{(POS_W-SHIFT_W){s0_hy_r[SHIFT_W-1]}}, s0_hy_r});
  assign w16  = $signed({{(POS_W-SIDE_W){1'b0}}, w_sat});
  assign h16  = $signed({{(POS_W-SIDE_W){1'b0}}, h_sat});
  assign w_hi = w16 + $signed(MARGIN_W);
  assign h_hi = h16 + $signed(MARGIN_W);

  assign outside   = bx[POS_W-1] || (bx >= w16) || by[POS_W-1] || (by >= h16);
  assign margin_ok = (bx >= POS_LO) && (by >= POS_LO) && (bx <= w_hi) && (by <= h_hi);
  assign pix_match = (s0_fp_r[PIX_W-1:24] == '0) &&
                     ((s0_bp_r[PIX_W-1:24] != '0) || (s0_fp_r == s0_bp_r));
  assign match     = outside ? margin_ok : pix_match;

  assign hx15 = $signed({s0_hx_r[SHIFT_W-1], s0_hx_r});
  assign hy15 = $signed({s0_hy_r[SHIFT_W-1], s0_hy_r});
  assign in_bounds = (hx15 >= mx_min_r) && (hx15 <= mx_max_r) &&
                     (hy15 >= my_min_r) && (hy15 <= my_max_r);

  // Accumulate: count, close the shift, keep the strictly better shift
  logic [CNT_W-1:0] samples_inc, match_inc;
  logic             close_shift;

  assign samples_inc = sat_inc(samples_run_r);
  assign match_inc   = s1_hit_r ? sat_inc(match_run_r) : match_run_r;
  assign close_shift = s1_last_s_r || s1_last_h_r;

  always_comb begin
    match_run_nxt    = match_inc;
    samples_run_nxt  = samples_inc;
    best_nxt         = best_r;
    best_h_nxt       = best_h_r;
    best_v_nxt       = best_v_r;
    samples_last_nxt = samples_last_r;
    if (close_shift) begin
      samples_last_nxt = samples_inc;
      if (s1_inb_r && (match_inc > best_r)) begin
        best_nxt   = match_inc;
        best_h_nxt = s1_hx_r;
        best_v_nxt = s1_hy_r;
      end
      match_run_nxt   = '0;
      samples_run_nxt = '0;
    end
  end

  // Output formatting
  logic                    use_best;
  logic [CNT_W+2:0]        best_x5, samples_x4;
  logic signed [MOT_W-1:0] org_x15, org_y15;

  assign org_x15    = $signed({{(MOT_W-SIDE_W){origin_x_r[SIDE_W-1]}}, origin_x_r});
  assign org_y15    = $signed({{(MOT_W-SIDE_W){origin_y_r[SIDE_W-1]}}, origin_y_r});
  assign use_best   = (res_best_r != '0) && (w_sat != '0) && (h_sat != '0);
  assign best_x5    = {1'b0, res_best_r, 2'b00} + {3'b000, res_best_r};
  assign samples_x4 = {1'b0, res_samples_r, 2'b00};

  // Valid bits and search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r     <= 1'b0;
      s1_valid_r     <= 1'b0;
      res_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      match_run_r    <= '0;
      samples_run_r  <= '0;
      best_r         <= '0;
      samples_last_r <= '0;
      best_h_r       <= '0;
      best_v_r       <= '0;
    end else begin
      if (out_free) begin
        out_valid_r <= res_valid_r;
      end
      if (adv) begin
        s0_valid_r  <= in_tvalid;
        s1_valid_r  <= s0_valid_r;
        res_valid_r <= s1_valid_r && s1_last_h_r;
        if (s1_valid_r) begin
          match_run_r   <= match_run_nxt;
          samples_run_r <= samples_run_nxt;
          if (s1_last_h_r) begin
            // clear for a new search
            best_r         <= '0;
            samples_last_r <= '0;
            best_h_r       <= '0;
            best_v_r       <= '0;
          end else begin
            best_r         <= best_nxt;
            samples_last_r <= samples_last_nxt;
            best_h_r       <= best_h_nxt;
            best_v_r       <= best_v_nxt;
          end
        end
      end
    end
  end

  // Payload stages: advance with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sx_r     <= in_tdata[11:0];
      s0_sy_r     <= in_tdata[23:12];
      s0_hx_r     <= in_tdata[37:24];
      s0_hy_r     <= in_tdata[51:38];
      s0_fp_r     <= in_tdata[83:52];
      s0_bp_r     <= in_tdata[115:84];
      s0_last_s_r <= in_tlast;
      s0_last_h_r <= in_tuser;

      s1_hit_r    <= in_bounds && match;
      s1_inb_r    <= in_bounds;
      s1_last_s_r <= s0_last_s_r;
      s1_last_h_r <= s0_last_h_r;
      s1_hx_r     <= s0_hx_r;
      s1_hy_r     <= s0_hy_r;

      res_best_r    <= best_nxt;
      res_samples_r <= samples_last_nxt;
      res_h_r       <= best_h_nxt;
      res_v_r       <= best_v_nxt;
    end
  end

  // Output register: load when empty or being taken, else hold the beat
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_best_r    <= res_best_r;
      out_samples_r <= res_samples_r;
      out_ox_r      <= use_best ? org_x15 + $signed({res_h_r[SHIFT_W-1], res_h_r}) : org_x15;
      out_oy_r      <= use_best ? org_y15 + $signed({res_v_r[SHIFT_W-1], res_v_r}) : org_y15;
      out_suspect_r <= use_best && (best_x5 < samples_x4);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_suspect_r;
  assign out_tdata  = {4'b0000, out_samples_r, out_best_r, out_oy_r, out_ox_r};

  // Checks
  `OSMV_ASSERT_ALWAYS(a_run_order, match_run_r <= samples_run_r,
    "match count of the open shift exceeds its sample count")
  `OSMV_ASSERT_IMP(a_zero_not_suspect, out_valid_r && (out_best_r == '0), !out_suspect_r,
    "suspect flag set on a search without matches")
  `OSMV_ASSERT_IMP(a_zero_at_origin, out_valid_r && (out_best_r == '0), out_ox_r == org_x15,
    "search without matches does not report the origin")

endmodule

FILE: tb/sv/offset_search_match_vote_checker.sv
// Scoreboard for offset_search_match_vote_top: follows register writes, predicts
// the vote of every closed search and compares it with each result beat.
// Depends on osmv_pkg for widths and register indexes.
module offset_search_match_vote_checker
  import osmv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [MOT_W-1:0]      cfg_data,
  output int                    mismatch_count,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hFF00_0000;
  localparam logic [CNT_W-1:0] CAP = '1;

  typedef struct {
    logic [MOT_W-1:0] off_x;
    logic [MOT_W-1:0] off_y;
    logic             suspect;
    logic [CNT_W-1:0] best;
    logic [CNT_W-1:0] total;
  } vote_t;

  vote_t expected_votes[$];
  int    errors = 0;

  // Register copy
  logic        [SIDE_W-1:0] bg_w, bg_h;
  logic signed [SIDE_W-1:0] org_x, org_y;
  logic signed [MOT_W-1:0]  x_lo, x_hi, y_lo, y_hi;

  // Search state
  logic        [CNT_W-1:0]   run_hits, run_seen, lead_hits, closed_seen;
  logic signed [SHIFT_W-1:0] lead_dx, lead_dy;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c < CAP) ? c + 1'b1 : CAP;
  endfunction

  task automatic forget_search();
    run_hits = '0;
    run_seen = '0;
    lead_hits = '0;
    closed_seen = '0;
    lead_dx = '0;
    lead_dy = '0;
  endtask

  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t ns vote %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Score one sample beat; close the shift and the search where marked
  task automatic score_sample(input logic [IN_DATA_W-1:0] d, input logic end_shift,
                              input logic end_search);
    int sx, sy, dx, dy, bx, by, w, h;
    logic [PIX_W-1:0] fp, bp;
    bit allowed, hit;
    vote_t v;
    sx = d[11:0];
    sy = d[23:12];
    dx = $signed(d[37:24]);
    dy = $signed(d[51:38]);
    fp = d[83:52];
    bp = d[115:84];
    w = (bg_w > MAX_SIDE) ? MAX_SIDE : bg_w;
    h = (bg_h > MAX_SIDE) ? MAX_SIDE : bg_h;
    allowed = dx >= x_lo && dx <= x_hi && dy >= y_lo && dy <= y_hi;
    bx = sx + int'(org_x) + dx;
    by = sy + int'(org_y) + dy;

    // Outside the background only the margin counts; inside, compare pixels
    if (bx < 0 || bx >= w || by < 0 || by >= h)
      hit = bx >= -MARGIN && by >= -MARGIN && bx <= w + MARGIN && by <= h + MARGIN;
    else if ((fp & ALPHA_MASK) != 0)
      hit = 1'b0;
    else if ((bp & ALPHA_MASK) != 0)
      hit = 1'b1;
    else
      hit = fp == bp;

    run_seen = bump(run_seen);
    if (allowed && hit) run_hits = bump(run_hits);

    // Close the shift; a strictly higher count takes the lead
    if (end_shift || end_search) begin
      closed_seen = run_seen;
      if (allowed && run_hits > lead_hits) begin
        lead_hits = run_hits;
        lead_dx = dx;
        lead_dy = dy;
      end
      run_hits = '0;
      run_seen = '0;
    end

    if (end_search) begin
      v.off_x = MOT_W'(int'(org_x));
      v.off_y = MOT_W'(int'(org_y));
      v.suspect = 1'b0;
      if (lead_hits != 0 && w != 0 && h != 0) begin
        v.off_x = MOT_W'(int'(org_x) + int'(lead_dx));
        v.off_y = MOT_W'(int'(org_y) + int'(lead_dy));
        v.suspect = longint'(lead_hits) * 5 < longint'(closed_seen) * 4;
      end
      v.best = lead_hits;
      v.total = closed_seen;
      expected_votes = {expected_votes, v};
      forget_search();
    end
  endtask

  // Compare a result beat with the oldest pending vote
  task automatic check_vote();
    vote_t want;
    if (expected_votes.size() == 0) begin
      flag_mismatch("beat with no search closed, offset_x",
                    $signed(out_tdata[14:0]), 0);
    end else begin
      want = expected_votes.pop_front();
      if (out_tdata[14:0] !== want.off_x)
        flag_mismatch("offset_x", $signed(out_tdata[14:0]), $signed(want.off_x));
      if (out_tdata[29:15] !== want.off_y)
        flag_mismatch("offset_y", $signed(out_tdata[29:15]), $signed(want.off_y));
      if (out_tuser !== want.suspect)
        flag_mismatch("suspect", out_tuser, want.suspect);
      if (out_tdata[48:30] !== want.best)
        flag_mismatch("best_count", out_tdata[48:30], want.best);
      if (out_tdata[67:49] !== want.total)
        flag_mismatch("sample_total", out_tdata[67:49], want.total);
      if (out_tdata[71:68] !== 4'h0)
        flag_mismatch("pad", out_tdata[71:68], 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bg_w = 13'd256;
      bg_h = 13'd256;
      org_x = '0;
      org_y = '0;
      x_lo = -15'sd9999;
      x_hi = 15'sd9999;
      y_lo = -15'sd9999;
      y_hi = 15'sd9999;
      forget_search();
      expected_votes.delete();
    end else begin
      // Apply register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BACK_WIDTH:   bg_w = cfg_data[SIDE_W-1:0];
          REG_BACK_HEIGHT:  bg_h = cfg_data[SIDE_W-1:0];
          REG_ORIGIN_X:     org_x = cfg_data[SIDE_W-1:0];
          REG_ORIGIN_Y:     org_y = cfg_data[SIDE_W-1:0];
          REG_MOTION_X_MIN: x_lo = cfg_data;
          REG_MOTION_X_MAX: x_hi = cfg_data;
          REG_MOTION_Y_MIN: y_lo = cfg_data;
          REG_MOTION_Y_MAX: y_hi = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_vote();
      if (in_tvalid && in_tready) score_sample(in_tdata, in_tlast, in_tuser);
    end
    pending_results <= expected_votes.size();
    mismatch_count <= errors;
  end

endmodule

FILE: tb/sv/offset_search_match_vote_top_tb.sv
// Testbench top for offset_search_match_vote_top: drives sample beats, register
// settings and result back-pressure; the verdict comes from the checker's count.
// Depends on osmv_pkg, offset_search_match_vote_top and offset_search_match_vote_checker.
module offset_search_match_vote_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import osmv_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [MOT_W-1:0]      cfg_data = '0;

  int fail_total;
  int results_due;
  int items_sent = 0;
  bit calm = 1'b0;

  // Settings currently programmed, for aiming samples at the background
  int cur_w = 256, cur_h = 256, cur_ox = 0, cur_oy = 0;
  int cur_xl = -9999, cur_xh = 9999, cur_yl = -9999, cur_yh = 9999;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  offset_search_match_vote_top u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  offset_search_match_vote_checker u_vote_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count(fail_total),
    .pending_results(results_due)
  );

  // Send one sample beat after a random gap; hold valid until accepted
  task automatic send_sample(int sx, int sy, int hx, int hy, logic [31:0] fp,
                             logic [31:0] bp, bit end_shift, bit end_search);
    int gap;
    bit took;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'h0, bp, fp, 14'(hy), 14'(hx), 12'(sy), 12'(sx)};
    in_tlast <= end_shift;
    in_tuser <= end_search;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [MOT_W-1:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Program all registers; junk goes into the unused top bits of 13-bit ones
  task automatic apply_setting(int wv, int hv, int ox, int oy, int xl, int xh,
                               int yl, int yh);
    write_reg(REG_BACK_WIDTH, {2'($urandom), 13'(wv)});
    write_reg(REG_BACK_HEIGHT, {2'($urandom), 13'(hv)});
    write_reg(REG_ORIGIN_X, {2'($urandom), 13'(ox)});
    write_reg(REG_ORIGIN_Y, {2'($urandom), 13'(oy)});
    write_reg(REG_MOTION_X_MIN, 15'(xl));
    write_reg(REG_MOTION_X_MAX, 15'(xh));
    write_reg(REG_MOTION_Y_MIN, 15'(yl));
    write_reg(REG_MOTION_Y_MAX, 15'(yh));
    cfg_valid <= 1'b0;
    cur_w = (wv > MAX_SIDE) ? MAX_SIDE : wv;
    cur_h = (hv > MAX_SIDE) ? MAX_SIDE : hv;
    cur_ox = ox;
    cur_oy = oy;
    cur_xl = xl;
    cur_xh = xh;
    cur_yl = yl;
    cur_yh = yh;
  endtask

  // Drop valid, wait for every vote, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly shifts inside the bounds or near zero, sometimes anywhere
  function automatic int shift_pick(int lo, int hi);
    int a, b;
    a = (lo < -8192) ? -8192 : lo;
    b = (hi > 8191) ? 8191 : hi;
    if (a <= b && $urandom_range(0, 9) < 4)
      return a + int'($urandom_range(0, (b - a > 12) ? 12 : b - a));
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, 20)) - 10;
    return $signed(14'($urandom));
  endfunction

  // Aim the sample near the background so edges and margins get hit
  task automatic send_aimed(int hx, int hy, bit end_shift, bit end_search);
    int sx, sy;
    logic [31:0] fp, bp;
    sx = int'($urandom_range(0, cur_w + 80)) - 40 - cur_ox - hx;
    if (sx < 0 || sx > 4095) sx = $urandom_range(0, 4095);
    sy = int'($urandom_range(0, cur_h + 80)) - 40 - cur_oy - hy;
    if (sy < 0 || sy > 4095) sy = $urandom_range(0, 4095);
    if ($urandom_range(0, 3) == 0) fp = {8'($urandom_range(1, 255)), 24'($urandom)};
    else fp = {8'h00, 24'($urandom)};
    case ($urandom_range(0, 3))
      0, 1: bp = fp;
      2: bp = {8'($urandom_range(1, 255)), 24'($urandom)};
      default: bp = $urandom;
    endcase
    send_sample(sx, sy, hx, hy, fp, bp, end_shift, end_search);
  endtask

  // One well-formed search: a few shifts of a few samples each
  task automatic random_search();
    int shifts, per, hx, hy;
    bit fin_shift, fin_search;
    calm = ($urandom_range(0, 3) == 0);
    shifts = $urandom_range(1, 4);
    for (int s = 0; s < shifts; s++) begin
      hx = shift_pick(cur_xl, cur_xh);
      hy = shift_pick(cur_yl, cur_yh);
      per = $urandom_range(1, 6);
      for (int k = 0; k < per; k++) begin
        fin_shift = (k == per - 1);
        fin_search = fin_shift && (s == shifts - 1);
        // now and then close the search without marking the shift
        if (fin_search && $urandom_range(0, 5) == 0) fin_shift = 1'b0;
        send_aimed(hx, hy, fin_shift, fin_search);
      end
    end
  endtask

  task automatic random_phase(int quota);
    int stop;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      if ($urandom_range(0, 9) < 8) begin
        random_search();
      end else begin
        // noise: any field, stray markers
        repeat ($urandom_range(1, 3))
          send_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $signed(14'($urandom)), $signed(14'($urandom)),
                      $urandom, $urandom, $urandom_range(0, 7) == 0,
                      $urandom_range(0, 15) == 0);
      end
    end
    random_search();
    settle();
  endtask

  // Result side: either ready in advance or stall after valid shows up
  initial begin : result_sink
    int stall;
    bit seen;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        do begin
          @(negedge clk);
          seen = out_tvalid;
          @(posedge clk);
        end while (!seen);
        repeat (stall - 1) @(posedge clk);
        out_tready <= 1'b1;
      end
      do begin
        @(negedge clk);
        seen = out_tvalid;
        @(posedge clk);
      end while (!seen);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: close on the search marker alone
    send_sample(10, 10, 0, 0, 32'h0012_3456, 32'h0012_3456, 1'b0, 1'b1);
    // transparent frame misses, transparent background matches
    send_sample(20, 30, 5, -6, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(21, 30, 5, -6, 32'h0000_0000, 32'h0100_0000, 1'b1, 1'b1);
    // nothing matches: origin comes back
    send_sample(100, 100, 0, 0, 32'hFFFF_FFFF, 32'h00AB_CDEF, 1'b1, 1'b1);
    // equal counts: the earlier shift stays
    send_sample(40, 40, 3, 4, 32'h0000_0007, 32'h0000_0007, 1'b1, 1'b0);
    send_sample(40, 40, -2, 7, 32'h0000_0009, 32'h0000_0009, 1'b1, 1'b1);
    // margin edges on both axes
    send_sample(0, 100, -32, 0, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(0, 100, -33, 0, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(256, 100, 32, 0, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(256, 100, 33, 0, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(100, 0, 0, -32, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(100, 0, 0, -33, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(100, 256, 0, 32, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(100, 256, 0, 33, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(256, 256, 0, 0, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(255, 255, 0, 0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    // field extremes
    send_sample(4095, 4095, -8192, 8191, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(4095, 0, 8191, -8192, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(0, 0, 0, 0, 32'h0000_0000, 32'h00FF_FFFF, 1'b1, 1'b0);
    send_sample(3, 3, 0, 0, 32'h00FF_FFFF, 32'h00FF_FFFF, 1'b1, 1'b1);
    settle();

    random_phase(95);
    // narrow bounds: out-of-bounds shifts never score
    apply_setting(64, 48, 5, -3, -4, 6, -5, 3);
    random_phase(95);
    // zero width: origin always
    apply_setting(0, 100, 100, -50, -9999, 9999, -9999, 9999);
    random_phase(95);
    // widest values, width saturates
    apply_setting(8191, 4096, -4096, 4095, -16384, 16383, -16384, 16383);
    random_phase(95);
    // empty bound ranges, smallest background
    apply_setting(1, 1, 4095, -4096, 16383, -16384, 16383, -16384);
    random_phase(95);
    // zero height
    apply_setting(4096, 0, 0, 0, -20, 20, -20, 20);
    random_phase(95);
    // only the null shift allowed
    apply_setting(33, 17, -20, 12, 0, 0, 0, 0);
    random_phase(95);
    apply_setting(200, 150, 0, 0, -8, 8, -8, 8);
    random_phase(40);

    if (fail_total == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/osmv_pkg.sv
rtl/offset_search_match_vote_top.sv
tb/sv/offset_search_match_vote_checker.sv
tb/sv/offset_search_match_vote_top_tb.sv
